FILE: design/mklb_pkg.sv
// Shared constants, types and mask helpers for the masked key lower-bound search.
package mklb_pkg;

  // Default sizing
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int MAX_KEY_BYTES_DEF = 8;

  // Field widths
  localparam int KEY_W      = 64;
  localparam int IDX_W      = 10;
  localparam int POS_W      = 11;
  localparam int KB_W       = 4;
  localparam int MASK_W     = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // Commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_BYTE_MASK = 1'b1;

  // Register reset values
  localparam logic [KB_W-1:0]   KEY_BYTES_RST = 4'd8;
  localparam logic [MASK_W-1:0] LAST_MASK_RST = 8'hff;

  // Status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_START_ERR = 1'b1;

  // Search request handed to the controller
  typedef struct packed {
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_end;
    logic [KEY_W-1:0] query;
    logic [KEY_W-1:0] stored_mask;
    logic             nonempty;
  } srch_req_t;

  // Search result
  typedef struct packed {
    logic [POS_W-1:0] found_position;
    logic             status;
  } srch_res_t;

  // Keep mask for a stored key: full compared bytes, last one under the byte mask
  function automatic logic [KEY_W-1:0] stored_key_mask(logic [KB_W-1:0] nbytes,
                                                       logic [MASK_W-1:0] last_mask);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b + 1 < int'(nbytes)) begin
        m[KEY_W-1-8*b -: 8] = 8'hff;
      end else if (b + 1 == int'(nbytes)) begin
        m[KEY_W-1-8*b -: 8] = last_mask;
      end
    end
    return m;
  endfunction

  // Keep mask for the query: all compared bytes
  function automatic logic [KEY_W-1:0] query_key_mask(logic [KB_W-1:0] nbytes);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < int'(nbytes)) begin
        m[KEY_W-1-8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

FILE: design/mklb_key_ram.sv
// Key table: one write port, one read port with registered read data.
module mklb_key_ram #(
  parameter int DEPTH = mklb_pkg::TABLE_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [mklb_pkg::KEY_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [mklb_pkg::KEY_W-1:0] rdata_o
);

  logic [mklb_pkg::KEY_W-1:0] mem [DEPTH];
  logic [mklb_pkg::KEY_W-1:0] rdata_q;

  // Store a key
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one entry into the registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mklb_search_ctrl.sv
// Binary search sequencer: one table read per halving step, result held until taken.
module mklb_search_ctrl #(
  parameter int TABLE_ENTRIES = mklb_pkg::TABLE_ENTRIES_DEF,
  parameter int AW            = $clog2(TABLE_ENTRIES),
  parameter int PW            = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  mklb_pkg::srch_req_t        req_i,
  output logic                       busy_o,
  output logic                       res_valid_o,
  output mklb_pkg::srch_res_t        res_o,
  input  logic                       res_ready_i,
  output logic                       re_o,
  output logic [AW-1:0]              raddr_o,
  input  logic [mklb_pkg::KEY_W-1:0] rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [31:0]   TE32   = 32'(TABLE_ENTRIES);
  localparam logic [PW-1:0] TE_POS = PW'(TABLE_ENTRIES);

  logic [1:0]                 state_q, state_d;
  logic [PW-1:0]              lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [mklb_pkg::KEY_W-1:0] query_q, query_d, smask_q, smask_d;
  mklb_pkg::srch_res_t        res_q, res_d;

  logic [PW-1:0] lo_init, hi_init, cur_lo, cur_hi, mid_next;
  logic          key_less;

  // Clamp the requested range to the table
  always_comb begin
    lo_init = (32'(req_i.range_start) > TE32) ? TE_POS : PW'(req_i.range_start);
    hi_init = (32'(req_i.range_end) > TE32) ? TE_POS : PW'(req_i.range_end);
  end

  // Compare the fetched key against the query and narrow the interval
  assign key_less = (rdata_i & smask_q) < query_q;

  always_comb begin
    if (state_q == S_IDLE) begin
      cur_lo = lo_init;
      cur_hi = hi_init;
    end else if (key_less) begin
      cur_lo = mid_q + PW'(1);
      cur_hi = hi_q;
    end else begin
      cur_lo = lo_q;
      cur_hi = mid_q;
    end
    mid_next = cur_lo + ((cur_hi - cur_lo) >> 1);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    query_d = query_q;
    smask_d = smask_q;
    res_d   = res_q;
    re_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          query_d = req_i.query;
          smask_d = req_i.stored_mask;
          if (req_i.range_start > req_i.range_end) begin
            res_d   = '{found_position: '0, status: mklb_pkg::STATUS_START_ERR};
            state_d = S_DONE;
          end else if (!req_i.nonempty) begin
            res_d   = '{found_position: '0, status: mklb_pkg::STATUS_OK};
            state_d = S_DONE;
          end else if (cur_lo < cur_hi) begin
            re_o    = 1'b1;
            lo_d    = cur_lo;
            hi_d    = cur_hi;
            mid_d   = mid_next;
            state_d = S_WAIT;
          end else begin
            res_d   = '{found_position: mklb_pkg::POS_W'(cur_lo),
                        status: mklb_pkg::STATUS_OK};
            state_d = S_DONE;
          end
        end
      end
      S_WAIT: begin
        lo_d = cur_lo;
        hi_d = cur_hi;
        if (cur_lo < cur_hi) begin
          re_o  = 1'b1;
          mid_d = mid_next;
        end else begin
          res_d   = '{found_position: mklb_pkg::POS_W'(cur_lo),
                      status: mklb_pkg::STATUS_OK};
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign raddr_o     = mid_next[AW-1:0];
  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Interval and result payload
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    query_q <= query_d;
    smask_q <= smask_d;
    res_q   <= res_d;
  end

endmodule

FILE: design/masked_key_lower_bound_search.sv
// Top level: masked key lower-bound search over a table of sorted keys.
//
// Input channel (in_valid_i / in_stall_o) carries one item per transfer. A write
// item (cmd 0) stores key_value_i at write_index_i and yields no result; an
// index at or above the table size is dropped. A search item (cmd 1) yields one
// result on the output channel (out_valid_o / out_stall_i): the first position
// in [range_start_i, range_end_i) whose stored key, last compared byte ANDed
// with the byte mask, is not less than the query.
// A write is stored in the key memory. A search takes one halving step per
// registered read of the key memory inside the step loop; start-after-end or an
// empty table yields a result without reading the memory.
// One item is worked at a time; the output register lets the next item be
// taken while a finished result waits.
// Reset clears the non-empty flag and the two registers (key bytes 8, mask ff);
// the table contents stay undefined until written. While the receiver stalls,
// the result holds in the output register and the block holds a second result
// inside until the first is transferred.
// Configuration: write cfg_data_i to register cfg_index_i (0 key bytes, 1 last
// byte mask) with cfg_we_i while the block is idle.
module masked_key_lower_bound_search #(
  parameter int TABLE_ENTRIES = mklb_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_KEY_BYTES = mklb_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [mklb_pkg::IDX_W-1:0]      write_index_i,
  input  logic [mklb_pkg::KEY_W-1:0]      key_value_i,
  input  logic [mklb_pkg::POS_W-1:0]      range_start_i,
  input  logic [mklb_pkg::POS_W-1:0]      range_end_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mklb_pkg::POS_W-1:0]      found_position_o,
  output logic                            status_o,
  input  logic                            cfg_we_i,
  input  logic [mklb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mklb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int          AW     = $clog2(TABLE_ENTRIES);
  localparam int          PW     = $clog2(TABLE_ENTRIES + 1);
  localparam logic [31:0] TE32   = 32'(TABLE_ENTRIES);
  localparam logic [mklb_pkg::KB_W-1:0] MAXB = mklb_pkg::KB_W'(MAX_KEY_BYTES);

  logic [mklb_pkg::KB_W-1:0]   key_bytes_q, key_bytes_d;
  logic [mklb_pkg::MASK_W-1:0] last_mask_q, last_mask_d;
  logic                        nonempty_q, nonempty_d;
  logic                        out_valid_q, out_valid_d;
  mklb_pkg::srch_res_t         out_res_q, out_res_d;

  logic                        accept, wr_en, srch_start, busy;
  logic [mklb_pkg::KB_W-1:0]   eff_bytes;
  mklb_pkg::srch_req_t         req;
  mklb_pkg::srch_res_t         res;
  logic                        res_valid, res_ready;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [mklb_pkg::KEY_W-1:0]  rd_data;

  // Input transfer and command decode
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign wr_en      = accept && (cmd_i == mklb_pkg::CMD_WRITE) &&
                      (32'(write_index_i) < TE32);
  assign srch_start = accept && (cmd_i == mklb_pkg::CMD_SEARCH);

  // Effective key length
  always_comb begin
    if (key_bytes_q == '0) begin
      eff_bytes = mklb_pkg::KB_W'(1);
    end else if (key_bytes_q > MAXB) begin
      eff_bytes = MAXB;
    end else begin
      eff_bytes = key_bytes_q;
    end
    if (eff_bytes > mklb_pkg::KB_W'(8)) begin
      eff_bytes = mklb_pkg::KB_W'(8);
    end
  end

  // Build the search request
  always_comb begin
    req.range_start = range_start_i;
    req.range_end   = range_end_i;
    req.query       = key_value_i & mklb_pkg::query_key_mask(eff_bytes);
    req.stored_mask = mklb_pkg::stored_key_mask(eff_bytes, last_mask_q);
    req.nonempty    = nonempty_q;
  end

  mklb_key_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(write_index_i)),
    .wdata_i (key_value_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mklb_search_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW),
    .PW            (PW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (srch_start),
    .req_i       (req),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .re_o        (rd_en),
    .raddr_o     (rd_addr),
    .rdata_i     (rd_data)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration writes and table flag
  always_comb begin
    key_bytes_d = key_bytes_q;
    last_mask_d = last_mask_q;
    nonempty_d  = nonempty_q || wr_en;
    if (cfg_we_i) begin
      case (cfg_index_i)
        mklb_pkg::REG_KEY_BYTES:      key_bytes_d = cfg_data_i[mklb_pkg::KB_W-1:0];
        mklb_pkg::REG_LAST_BYTE_MASK: last_mask_d = cfg_data_i[mklb_pkg::MASK_W-1:0];
        default: begin
          key_bytes_d = key_bytes_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q <= mklb_pkg::KEY_BYTES_RST;
      last_mask_q <= mklb_pkg::LAST_MASK_RST;
      nonempty_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      key_bytes_q <= key_bytes_d;
      last_mask_q <= last_mask_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign found_position_o = out_res_q.found_position;
  assign status_o         = out_res_q.status;

endmodule
